// ===== rtl/core/stq_pkg.sv =====
// Shared types and constants for the software timer queue.
// No dependencies; every module of the block imports this package.
`default_nettype none

package stq_pkg;

    localparam int TIME_W         = 32;
    localparam int ID_W           = 3;
    localparam int NUM_TIMERS_DEF = 8;
    localparam int FIRE_CAP       = 64;
    localparam int CNT_W          = $clog2(FIRE_CAP + 1);
    localparam int S_TDATA_W      = 72;
    localparam int M_TDATA_W      = 8;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_STOP   = 2'd1,
        CMD_CHANGE = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DECIDE,
        ST_FINAL
    } state_t;

    // One timer slot as read from the slot memories.
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] period_ticks;
        logic              repeat_flag;
    } entry_t;

    // Earliest due slot found by one scan pass (slot index travels separately).
    typedef struct packed {
        logic              found;
        logic              repeat_flag;
        logic [TIME_W-1:0] deadline;
    } scan_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/stq_store.sv =====
// Slot storage: one memory for start time and mode, one for the period.
// Depends on stq_pkg. Reads are registered; unwritten slots read as zero.
`default_nettype none

module stq_store
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int IDX_W      = $clog2(NUM_TIMERS)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output entry_t                 rd_entry,
    input  wire logic              wa_en,
    input  wire logic [IDX_W-1:0]  wa_addr,
    input  wire logic [TIME_W-1:0] wa_start,
    input  wire logic              wa_repeat,
    input  wire logic              wp_en,
    input  wire logic [IDX_W-1:0]  wp_addr,
    input  wire logic [TIME_W-1:0] wp_period
);

    logic [TIME_W:0]   mem_a [NUM_TIMERS];
    logic [TIME_W-1:0] mem_p [NUM_TIMERS];

    logic [NUM_TIMERS-1:0] wr_a_reg;
    logic [NUM_TIMERS-1:0] wr_p_reg;
    logic [TIME_W:0]       rd_a_reg;
    logic [TIME_W-1:0]     rd_p_reg;
    logic                  ok_a_reg;
    logic                  ok_p_reg;

    always_ff @(posedge clk)
    begin
        if (wa_en)
        begin
            mem_a[wa_addr] <= {wa_start, wa_repeat};
        end
        if (wp_en)
        begin
            mem_p[wp_addr] <= wp_period;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem_a[rd_addr];
            rd_p_reg <= mem_p[rd_addr];
            ok_a_reg <= wr_a_reg[rd_addr];
            ok_p_reg <= wr_p_reg[rd_addr];
        end
    end

    // Written marks stand in for the zero reset of the slot memories.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_a_reg <= '0;
            wr_p_reg <= '0;
        end
        else
        begin
            if (wa_en)
            begin
                wr_a_reg[wa_addr] <= 1'b1;
            end
            if (wp_en)
            begin
                wr_p_reg[wp_addr] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        rd_entry.start_time   = ok_a_reg ? rd_a_reg[TIME_W:1] : '0;
        rd_entry.repeat_flag  = ok_a_reg ? rd_a_reg[0] : 1'b0;
        rd_entry.period_ticks = ok_p_reg ? rd_p_reg : '0;
    end

endmodule

`default_nettype wire

// ===== rtl/core/stq_scan.sv =====
// Two-stage scan unit: forms each slot's deadline, then keeps the earliest due one.
// Depends on stq_pkg. Fed one slot per cycle in ascending order by the top level.
`default_nettype none

module stq_scan
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int IDX_W      = $clog2(NUM_TIMERS)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic              in_valid,
    input  wire logic              in_last,
    input  wire logic [IDX_W-1:0]  in_idx,
    input  wire logic              in_active,
    input  wire entry_t            in_entry,
    input  wire logic [TIME_W-1:0] now_time,
    output scan_result_t           best,
    output logic [IDX_W-1:0]       best_idx,
    output logic                   done
);

    logic              a_valid_reg;
    logic              a_last_reg;
    logic [IDX_W-1:0]  a_idx_reg;
    logic              a_active_reg;
    logic              a_repeat_reg;
    logic [TIME_W-1:0] a_deadline_reg;

    logic              found_reg;
    logic              repeat_reg;
    logic [TIME_W-1:0] deadline_reg;
    logic [TIME_W-1:0] lag_best_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              done_reg;

    logic [TIME_W-1:0] lag;
    logic              better;

    always_ff @(posedge clk)
    begin
        a_idx_reg      <= in_idx;
        a_active_reg   <= in_active;
        a_repeat_reg   <= in_entry.repeat_flag;
        a_deadline_reg <= in_entry.start_time + in_entry.period_ticks;
    end

    // A slot is due when now lies less than half the counter range past its deadline.
    // Strictly larger lag wins, so the lower slot keeps a tie.
    always_comb
    begin
        lag    = now_time - a_deadline_reg;
        better = a_valid_reg && a_active_reg && !lag[TIME_W-1]
                 && (!found_reg || (lag > lag_best_reg));
    end

    always_ff @(posedge clk)
    begin
        if (better)
        begin
            repeat_reg   <= a_repeat_reg;
            deadline_reg <= a_deadline_reg;
            lag_best_reg <= lag;
            idx_reg      <= a_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            a_last_reg  <= in_valid && in_last;
            done_reg    <= a_valid_reg && a_last_reg && !clear;
            if (clear)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        best.found       = found_reg;
        best.repeat_flag = repeat_reg;
        best.deadline    = deadline_reg;
        best_idx         = idx_reg;
        done             = done_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/core/software_timer_queue.sv =====
// Software timer queue top level. Start, stop and change words are applied as they are accepted.
// A tick runs one scan pass per firing plus one final pass that finds none, which the run
// skips when it stops at the fire cap; a full output register can hold the run back.
// Each result is held in an output register, so one result may wait there.
// Reset clears all active marks and the slot contents read as zero until written.
`default_nettype none

module software_timer_queue
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // timer_id[2:0], period_value[34:3], repeat_mode[35], now_time[67:36], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // fired_id[2:0], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    // fired_valid[0]
    output logic                      m_tuser,
    output logic                      m_tlast
);

    localparam int IDX_W = $clog2(NUM_TIMERS);

    state_t state_reg, state_next;

    logic [IDX_W-1:0]      scan_idx_reg;
    logic                  rd_valid_reg;
    logic                  rd_last_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [NUM_TIMERS-1:0] active_reg;
    logic [IDX_W-1:0]      pending_id_reg;
    logic                  have_pending_reg;
    logic [CNT_W-1:0]      count_reg;

    logic              out_valid_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_fired_reg;
    logic              out_last_reg;

    // Input word fields.
    logic [ID_W-1:0]   in_id;
    logic [TIME_W-1:0] in_period;
    logic              in_mode;
    logic [TIME_W-1:0] in_now;
    cmd_t              in_cmd;
    logic [IDX_W-1:0]  in_slot;
    logic              in_ok;
    logic              s_accept;

    // Control from the state machine.
    logic              out_free;
    logic              out_load;
    logic [ID_W-1:0]   out_id;
    logic              out_fired;
    logic              out_last;
    logic              take;
    logic              finish;
    logic              scan_clear;
    logic              rd_en;
    logic              rd_last;

    // Memory write ports.
    logic              wa_en;
    logic [IDX_W-1:0]  wa_addr;
    logic [TIME_W-1:0] wa_start;
    logic              wa_repeat;
    logic              wp_en;

    entry_t            rd_entry;
    scan_result_t      best;
    logic [IDX_W-1:0]  best_idx;
    logic              scan_done;

    always_comb
    begin
        in_id     = s_tdata[2:0];
        in_period = s_tdata[34:3];
        in_mode   = s_tdata[35];
        in_now    = s_tdata[67:36];
        in_cmd    = cmd_t'(s_tuser);
        in_slot   = IDX_W'(in_id);
        in_ok     = int'(in_id) < NUM_TIMERS;
        s_tready  = (state_reg == ST_IDLE);
        s_accept  = s_tvalid && s_tready;
        out_free  = !out_valid_reg || m_tready;
        rd_en     = (state_reg == ST_SCAN);
        rd_last   = (scan_idx_reg == IDX_W'(NUM_TIMERS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        out_id     = '0;
        out_fired  = 1'b0;
        out_last   = 1'b0;
        take       = 1'b0;
        finish     = 1'b0;
        scan_clear = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && (in_cmd == CMD_TICK))
                begin
                    scan_clear = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // A firing is held back one pass so the last one can carry the run mark.
                if (best.found)
                begin
                    if (!have_pending_reg || out_free)
                    begin
                        take = 1'b1;
                        if (have_pending_reg)
                        begin
                            out_load  = 1'b1;
                            out_id    = ID_W'(pending_id_reg);
                            out_fired = 1'b1;
                        end
                        if (count_reg == CNT_W'(FIRE_CAP - 1))
                        begin
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            scan_clear = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_id     = have_pending_reg ? ID_W'(pending_id_reg) : '0;
                    out_fired  = have_pending_reg;
                    out_last   = 1'b1;
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Write port muxing: a start word, or the advance of a repeating timer that fired; change words write the period.
    always_comb
    begin
        if (take)
        begin
            wa_en     = best.repeat_flag;
            wa_addr   = best_idx;
            wa_start  = best.deadline;
            wa_repeat = 1'b1;
        end
        else
        begin
            wa_en     = s_accept && in_ok && (in_cmd == CMD_START);
            wa_addr   = in_slot;
            wa_start  = in_now;
            wa_repeat = in_mode;
        end
        wp_en = s_accept && in_ok && (in_cmd == CMD_CHANGE);
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_idx_reg;
        if (s_accept)
        begin
            now_reg <= in_now;
        end
        if (take)
        begin
            pending_id_reg <= best_idx;
        end
        if (out_load)
        begin
            out_id_reg    <= out_id;
            out_fired_reg <= out_fired;
            out_last_reg  <= out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg     <= '0;
            rd_valid_reg     <= 1'b0;
            rd_last_reg      <= 1'b0;
            active_reg       <= '0;
            have_pending_reg <= 1'b0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            rd_last_reg  <= rd_en && rd_last;
            if (scan_clear)
            begin
                scan_idx_reg <= '0;
            end
            else if (rd_en)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end

            if (s_accept && in_ok && (in_cmd == CMD_START))
            begin
                active_reg[in_slot] <= 1'b1;
            end
            else if (s_accept && in_ok && (in_cmd == CMD_STOP))
            begin
                active_reg[in_slot] <= 1'b0;
            end
            else if (take && !best.repeat_flag)
            begin
                active_reg[best_idx] <= 1'b0;
            end

            if (finish)
            begin
                have_pending_reg <= 1'b0;
                count_reg        <= '0;
            end
            else if (take)
            begin
                have_pending_reg <= 1'b1;
                count_reg        <= count_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    stq_store #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr   (scan_idx_reg),
        .rd_entry  (rd_entry),
        .wa_en     (wa_en),
        .wa_addr   (wa_addr),
        .wa_start  (wa_start),
        .wa_repeat (wa_repeat),
        .wp_en     (wp_en),
        .wp_addr   (in_slot),
        .wp_period (in_period)
    );

    stq_scan #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .in_valid  (rd_valid_reg),
        .in_last   (rd_last_reg),
        .in_idx    (rd_idx_reg),
        .in_active (active_reg[rd_idx_reg]),
        .in_entry  (rd_entry),
        .now_time  (now_reg),
        .best      (best),
        .best_idx  (best_idx),
        .done      (scan_done)
    );

    always_comb
    begin
        m_tvalid = out_valid_reg;
        m_tdata  = M_TDATA_W'(out_id_reg);
        m_tuser  = out_fired_reg;
        m_tlast  = out_last_reg;
    end

endmodule

`default_nettype wire

// ===== sim/stq_checker.sv =====
`timescale 1ns / 1ps
// Checker for the software timer queue. It watches both stream channels and keeps
// its own copy of the timer slots. Depends on stq_pkg for the widths and command codes.
module stq_checker
    import stq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    // timer_id[2:0], period_value[34:3], repeat_mode[35], now_time[67:36], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]           s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    // fired_id[2:0], zero pad
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    // fired_valid[0]
    input  wire logic                 m_tuser,
    input  wire logic                 m_tlast,
    output int                        errors,
    output int                        pending,
    output int                        words_in,
    output int                        ticks,
    output int                        empty_ticks,
    output int                        capped_ticks,
    output int                        results_checked
);

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            fired;
        logic            last;
    } firing_t;

    logic [TIME_W-1:0] slot_start  [NUM_TIMERS_DEF];
    logic [TIME_W-1:0] slot_period [NUM_TIMERS_DEF];
    logic              slot_repeat [NUM_TIMERS_DEF];
    logic              slot_active [NUM_TIMERS_DEF];

    firing_t firings_due[$];

    // Earliest due slot at the given time, or -1. A slot is due when the time
    // since its deadline, taken modulo 2^32, is below half the range.
    function automatic int earliest_due_slot(input logic [TIME_W-1:0] now);
        int                best;
        logic [TIME_W-1:0] best_lag;
        logic [TIME_W-1:0] lag;
        best     = -1;
        best_lag = '0;
        for (int s = 0; s < NUM_TIMERS_DEF; s++) begin
            if (slot_active[s]) begin
                lag = now - (slot_start[s] + slot_period[s]);
                if (!lag[TIME_W-1] && (best < 0 || lag > best_lag)) begin
                    best     = s;
                    best_lag = lag;
                end
            end
        end
        return best;
    endfunction

    function automatic void predict_tick(input logic [TIME_W-1:0] now);
        int      slot;
        int      count;
        firing_t f;
        count = 0;
        ticks++;
        while (count < FIRE_CAP) begin
            slot = earliest_due_slot(now);
            if (slot < 0)
                break;
            if (slot_repeat[slot])
                slot_start[slot] = slot_start[slot] + slot_period[slot];
            else
                slot_active[slot] = 1'b0;
            f.id    = slot[ID_W-1:0];
            f.fired = 1'b1;
            f.last  = 1'b0;
            firings_due.push_back(f);
            count++;
        end
        if (count == 0) begin
            empty_ticks++;
            f.id    = '0;
            f.fired = 1'b0;
            f.last  = 1'b1;
            firings_due.push_back(f);
        end else begin
            if (count == FIRE_CAP)
                capped_ticks++;
            f      = firings_due.pop_back();
            f.last = 1'b1;
            firings_due.push_back(f);
        end
    endfunction

    function automatic void apply_word(input cmd_t cmd, input logic [S_TDATA_W-1:0] d);
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        id  = d[2:0];
        now = d[67:36];
        words_in++;
        case (cmd)
            CMD_START: begin
                slot_start[id]  = now;
                slot_repeat[id] = d[35];
                slot_active[id] = 1'b1;
            end
            CMD_STOP:   slot_active[id] = 1'b0;
            CMD_CHANGE: slot_period[id] = d[34:3];
            default:    predict_tick(now);
        endcase
    endfunction

    function automatic void report_bad(input string why, input firing_t want,
                                       input firing_t got);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s: expected id=%0d fired=%b last=%b, got id=%0d fired=%b last=%b",
                     $time, why, want.id, want.fired, want.last, got.id, got.fired, got.last);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        firing_t got;
        firing_t want;
        if (!rst_n) begin
            for (int s = 0; s < NUM_TIMERS_DEF; s++) begin
                slot_start[s]  = '0;
                slot_period[s] = '0;
                slot_repeat[s] = 1'b0;
                slot_active[s] = 1'b0;
            end
            firings_due.delete();
            errors          = 0;
            words_in        = 0;
            ticks           = 0;
            empty_ticks     = 0;
            capped_ticks    = 0;
            results_checked = 0;
            pending        <= 0;
        end else begin
            // Results go first: a word taken at this edge cannot have caused one yet.
            if (m_tvalid && m_tready) begin
                got.id    = m_tdata[ID_W-1:0];
                got.fired = m_tuser;
                got.last  = m_tlast;
                results_checked++;
                if (firings_due.size() == 0) begin
                    want = '0;
                    report_bad("unexpected result", want, got);
                end else begin
                    want = firings_due.pop_front();
                    if (got.id !== want.id || got.fired !== want.fired
                        || got.last !== want.last)
                        report_bad("result mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready)
                apply_word(cmd_t'(s_tuser), s_tdata);
            pending <= firings_due.size();
        end
    end

endmodule

// ===== sim/tb_software_timer_queue.sv =====
`timescale 1ns / 1ps
// Testbench top for the software timer queue: clock, reset, stimulus and verdict.
// Needs stq_pkg, the block itself and stq_checker, which predicts and compares.
module tb_software_timer_queue;
    import stq_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int WORDS_PER_PH = 25;
    // The worst case is ticks at the fire cap plus long output stalls per result;
    // this limit is several times that over all words.
    localparam int LIMIT_CYCLES = 3_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    int errors, pending, words_in, ticks, empty_ticks, capped_ticks, results_checked;

    int                tx_idle_pct  = 0;
    int                rx_stall_pct = 0;
    int                hold_reqs    = 0;
    int                holds_done   = 0;
    int                cycle_count  = 0;
    logic [TIME_W-1:0] clock_now;

    software_timer_queue DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    stq_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .errors          (errors),
        .pending         (pending),
        .words_in        (words_in),
        .ticks           (ticks),
        .empty_ticks     (empty_ticks),
        .capped_ticks    (capped_ticks),
        .results_checked (results_checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("Simulation FAILED");
        $finish;
    end

    // Output side: random stalls, or one long hold-off when the stimulus asks for it.
    initial
    begin
        int held;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != holds_done)
            begin
                m_tready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                holds_done++;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_word(input cmd_t cmd, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] period, input logic mode,
                             input logic [TIME_W-1:0] now);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, now, mode, period, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering words until every predicted result has been seen.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed traffic around a slowly advancing clock, with some noise.
    task automatic random_word();
        int                pick;
        int                sel;
        logic [ID_W-1:0]   slot;
        logic [TIME_W-1:0] period;
        logic              mode;
        pick   = $urandom_range(99);
        sel    = $urandom_range(9);
        slot   = ID_W'($urandom_range(7));
        mode   = 1'($urandom_range(1));
        period = $urandom_range(60, 1);
        if (pick < 12)
        begin
            period = $urandom;
            if (period == '0)
                period = 1;
            send_word(cmd_t'($urandom_range(3)), slot, period, mode, $urandom);
        end
        else if (pick < 40)
            send_word(CMD_START, slot, period, mode, clock_now);
        else if (pick < 48)
            send_word(CMD_STOP, slot, period, mode, clock_now);
        else if (pick < 64)
        begin
            if (sel == 9)
            begin
                period = $urandom;
                if (period == '0)
                    period = 1;
            end
            else if (sel >= 7)
                period = $urandom_range(5000, 61);
            send_word(CMD_CHANGE, slot, period, mode, clock_now);
        end
        else
        begin
            clock_now = clock_now + $urandom_range(90);
            send_word(CMD_TICK, slot, period, mode, clock_now);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_START;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty tick, then a one-shot that is not yet due and then due.
        send_word(CMD_TICK,   3'd0, 32'd1,  1'b0, 32'd0);
        send_word(CMD_CHANGE, 3'd0, 32'd10, 1'b0, 32'd0);
        send_word(CMD_START,  3'd0, 32'd1,  1'b0, 32'd100);
        send_word(CMD_TICK,   3'd0, 32'd1,  1'b0, 32'd105);
        send_word(CMD_TICK,   3'd0, 32'd1,  1'b0, 32'd110);
        send_word(CMD_TICK,   3'd0, 32'd1,  1'b0, 32'd200);

        // Deadline order, ties going to the lower slot, a repeat firing twice.
        send_word(CMD_CHANGE, 3'd1, 32'd50, 1'b0, 32'd0);
        send_word(CMD_CHANGE, 3'd2, 32'd50, 1'b0, 32'd0);
        send_word(CMD_CHANGE, 3'd4, 32'd20, 1'b0, 32'd0);
        send_word(CMD_START,  3'd2, 32'd1,  1'b0, 32'd1000);
        send_word(CMD_START,  3'd1, 32'd1,  1'b0, 32'd1000);
        send_word(CMD_START,  3'd4, 32'd1,  1'b1, 32'd1010);
        send_word(CMD_TICK,   3'd0, 32'd1,  1'b0, 32'd1060);
        send_word(CMD_CHANGE, 3'd4, 32'h7FFF_FFFF, 1'b0, 32'd0);
        send_word(CMD_STOP,   3'd4, 32'd1,  1'b0, 32'd0);

        // Largest period wraps the deadline backwards on each firing, so the cap hits.
        send_word(CMD_CHANGE, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'd0);
        send_word(CMD_START,  3'd7, 32'd1,  1'b1, 32'hFFFF_FFFF);
        send_word(CMD_TICK,   3'd0, 32'd1,  1'b0, 32'hFFFF_FFFF);
        send_word(CMD_STOP,   3'd7, 32'd1,  1'b0, 32'd0);

        // Zero-period repeat from reset state fills the cap after an older one-shot.
        send_word(CMD_START,  3'd3, 32'd1,  1'b1, 32'd5);
        send_word(CMD_START,  3'd5, 32'd1,  1'b0, 32'd0);
        send_word(CMD_TICK,   3'd0, 32'd1,  1'b0, 32'd5);
        send_word(CMD_STOP,   3'd3, 32'd1,  1'b0, 32'd0);

        // Long output hold-off while ticks keep arriving, so the input backs up.
        send_word(CMD_CHANGE, 3'd6, 32'd1,  1'b0, 32'd0);
        send_word(CMD_START,  3'd6, 32'd1,  1'b1, 32'd2000);
        hold_reqs++;
        for (int k = 1; k <= 4; k++)
            send_word(CMD_TICK, 3'd0, 32'd1, 1'b0, 32'd2000 + 3 * k);
        send_word(CMD_STOP,   3'd6, 32'd1,  1'b0, 32'd0);
        drain();

        clock_now = 32'hFFFF_FC00;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
                default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            for (int n = 0; n < WORDS_PER_PH; n++)
                random_word();
            drain();
        end

        repeat (100)
            @(posedge clk);
        $display("Covered %0d words and %0d ticks: %0d empty, %0d stopped at the fire cap.",
                 words_in, ticks, empty_ticks, capped_ticks);
        $display("Checked %0d results, %0d mismatches, %0d still outstanding.",
                 results_checked, errors, pending);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
